// ===== design/pcc_pkg.sv =====
// ----------------------------------------------------------------------------
// pcc_pkg
// Shared types and constants of the pileup consensus caller: transfer
// payloads, item kinds and the command and status groups between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package pcc_pkg;

   // item kinds
   localparam logic [1:0] KIND_ADD   = 2'd0;
   localparam logic [1:0] KIND_CALL  = 2'd1;
   localparam logic [1:0] KIND_CLEAR = 2'd2;
   localparam logic [1:0] KIND_NONE  = 2'd3;

   // saturation limits and register reset value
   localparam int unsigned COV_WIDTH      = 18;
   localparam logic [17:0] COV_MAX        = 18'h3FFFF;
   localparam logic [8:0]  MISMATCH_MAX   = 9'h1FF;
   localparam logic [8:0]  THRESH_RESET   = 9'd128;

   // input transfer payload
   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] position;
      logic [1:0] base;
   } req_type;

   // result transfer payload
   typedef struct packed {
      logic [1:0]  called_base;
      logic        replaced;
      logic        changed;
      logic [17:0] coverage;
      logic [8:0]  mismatch_count;
   } rsp_type;

   // controller to datapath commands, at most one per cycle
   typedef struct packed {
      logic clear_step;
      logic capture;
      logic update;
      logic rank_pair;
      logic rank_final;
      logic product;
      logic finish;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic clear_last;
   } status_type;

endpackage

// ===== design/pcc_ctrl.sv =====
// ----------------------------------------------------------------------------
// pcc_ctrl
// Controller of the pileup consensus caller: table clearing after reset,
// input and result handshakes and the sequence of datapath steps per item.
// ----------------------------------------------------------------------------
module pcc_ctrl
   import pcc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_READ  = 3'd2;
   localparam logic [2:0] ST_PAIR  = 3'd3;
   localparam logic [2:0] ST_RANK  = 3'd4;
   localparam logic [2:0] ST_MUL   = 3'd5;
   localparam logic [2:0] ST_DONE  = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_READ;
            end
         end
         ST_READ: begin
            cmd.update = 1'b1;
            state_in   = ST_PAIR;
         end
         ST_PAIR: begin
            cmd.rank_pair = 1'b1;
            state_in      = ST_RANK;
         end
         ST_RANK: begin
            cmd.rank_final = 1'b1;
            state_in       = ST_MUL;
         end
         ST_MUL: begin
            cmd.product = 1'b1;
            state_in    = ST_DONE;
         end
         ST_DONE: begin
            // wait until the output register is free or being emptied
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // result valid flag
   always_comb begin
      priority if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== design/pcc_datapath.sv =====
// ----------------------------------------------------------------------------
// pcc_datapath
// Datapath of the pileup consensus caller: count table memory, row update,
// two-level ranking of the four counts, margin test and result register.
// ----------------------------------------------------------------------------
module pcc_datapath
   import pcc_pkg::*;
#(
   parameter int MAX_READ_LEN = 256,
   parameter int COUNT_WIDTH  = 16
)
(
   input  logic       clock,
   input  logic       reset,
   input  cmd_type    cmd,
   output status_type status,
   input  req_type    req_item,
   input  logic       csr_wr_en,
   input  logic [8:0] csr_wr_data,
   output rsp_type    rsp_item
);

   localparam int AW = $clog2(MAX_READ_LEN);
   localparam int CW = COUNT_WIDTH;
   localparam int SW = CW + 2;
   localparam int PW = CW + 11;
   localparam int XW = (SW > COV_WIDTH) ? SW : COV_WIDTH;

   typedef logic [3:0][CW-1:0] row_type;

   // count table, one row of four counts per position
   row_type mem [MAX_READ_LEN];

   logic [AW-1:0] clr_addr_ff;
   logic [8:0]    thr_ff;
   logic [8:0]    mismatch_ff;
   logic [8:0]    mismatch_in;
   req_type       item_ff;
   logic          in_range_ff;
   logic [AW-1:0] idx_ff;
   row_type       rd_ff;
   row_type       row_ff;
   row_type       new_row;
   logic          wr_row;
   logic [CW-1:0] pa_max_ff, pa_min_ff, pb_max_ff, pb_min_ff;
   logic [1:0]    pa_win_ff, pb_win_ff;
   logic [CW:0]   s01_ff, s23_ff;
   logic [CW-1:0] best_ff, second_ff;
   logic [1:0]    win_ff;
   logic [SW-1:0] total_ff;
   logic [PW-1:0] prod_ff;
   logic [CW+7:0] lhs_ff;
   logic [17:0]   cov_ff;
   logic [AW+8:0] pos_wide;
   logic          in_range;
   logic [XW-1:0] total_wide;
   logic          pass;
   logic          replaced;
   logic          changed;
   rsp_type       rsp_ff;

   // position range check and row index
   assign pos_wide = (AW + 9)'(req_item.position);
   assign in_range = pos_wide < (AW + 9)'(MAX_READ_LEN);

   // clearing sweep address
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else if (cmd.clear_step) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
      end
   end
   assign status.clear_last = (clr_addr_ff == AW'(MAX_READ_LEN - 1));

   // threshold register
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THRESH_RESET;
      end else if (csr_wr_en) begin
         thr_ff <= csr_wr_data;
      end
   end

   // item capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_ff     <= req_item;
         in_range_ff <= in_range;
         idx_ff      <= pos_wide[AW-1:0];
      end
   end

   // row update: saturating add, clear or keep
   always_comb begin
      for (int j = 0; j < 4; j++) begin
         unique case (item_ff.kind)
            KIND_ADD, KIND_CALL: begin
               if (2'(j) == item_ff.base && rd_ff[j] != '1) begin
                  new_row[j] = rd_ff[j] + CW'(1);
               end else begin
                  new_row[j] = rd_ff[j];
               end
            end
            KIND_CLEAR: begin
               new_row[j] = '0;
            end
            KIND_NONE: begin
               new_row[j] = rd_ff[j];
            end
         endcase
      end
   end
   assign wr_row = cmd.update && in_range_ff && (item_ff.kind != KIND_NONE);

   // table memory: registered read, one write port
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         rd_ff <= mem[pos_wide[AW-1:0]];
      end
      if (cmd.clear_step) begin
         mem[clr_addr_ff] <= '0;
      end else if (wr_row) begin
         mem[idx_ff] <= new_row;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         row_ff <= new_row;
      end
   end

   // first ranking level: two pairs and partial sums
   always_ff @(posedge clock) begin
      if (cmd.rank_pair) begin
         if (row_ff[1] > row_ff[0]) begin
            pa_max_ff <= row_ff[1];
            pa_min_ff <= row_ff[0];
            pa_win_ff <= 2'd1;
         end else begin
            pa_max_ff <= row_ff[0];
            pa_min_ff <= row_ff[1];
            pa_win_ff <= 2'd0;
         end
         if (row_ff[3] > row_ff[2]) begin
            pb_max_ff <= row_ff[3];
            pb_min_ff <= row_ff[2];
            pb_win_ff <= 2'd3;
         end else begin
            pb_max_ff <= row_ff[2];
            pb_min_ff <= row_ff[3];
            pb_win_ff <= 2'd2;
         end
         s01_ff <= (CW + 1)'(row_ff[0]) + (CW + 1)'(row_ff[1]);
         s23_ff <= (CW + 1)'(row_ff[2]) + (CW + 1)'(row_ff[3]);
      end
   end

   // second level: largest, true second largest, lowest code wins ties
   always_ff @(posedge clock) begin
      if (cmd.rank_final) begin
         if (pb_max_ff > pa_max_ff) begin
            best_ff   <= pb_max_ff;
            win_ff    <= pb_win_ff;
            second_ff <= (pa_max_ff > pb_min_ff) ? pa_max_ff : pb_min_ff;
         end else begin
            best_ff   <= pa_max_ff;
            win_ff    <= pa_win_ff;
            second_ff <= (pa_min_ff > pb_max_ff) ? pa_min_ff : pb_max_ff;
         end
         total_ff <= SW'(s01_ff) + SW'(s23_ff);
      end
   end

   // margin products and saturated coverage
   assign total_wide = XW'(total_ff);
   always_ff @(posedge clock) begin
      if (cmd.product) begin
         prod_ff <= PW'(thr_ff) * PW'(total_ff);
         lhs_ff  <= {best_ff - second_ff, 8'h00};
         if (!in_range_ff) begin
            cov_ff <= '0;
         end else if (total_wide > XW'(COV_MAX)) begin
            cov_ff <= COV_MAX;
         end else begin
            cov_ff <= total_wide[17:0];
         end
      end
   end

   // margin test and mismatch counter
   assign pass     = PW'(lhs_ff) >= prod_ff;
   assign replaced = (item_ff.kind == KIND_CALL) && in_range_ff && pass;
   assign changed  = replaced && (win_ff != item_ff.base);

   always_comb begin
      priority if (item_ff.kind == KIND_CLEAR) begin
         mismatch_in = '0;
      end else if (changed && mismatch_ff != MISMATCH_MAX) begin
         mismatch_in = mismatch_ff + 9'd1;
      end else begin
         mismatch_in = mismatch_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mismatch_ff <= '0;
      end else if (cmd.finish) begin
         mismatch_ff <= mismatch_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_ff.called_base    <= replaced ? win_ff : item_ff.base;
         rsp_ff.replaced       <= replaced;
         rsp_ff.changed        <= changed;
         rsp_ff.coverage       <= cov_ff;
         rsp_ff.mismatch_count <= mismatch_in;
      end
   end

   assign rsp_item = rsp_ff;

endmodule

// ===== design/pileup_consensus_caller_unit.sv =====
// ----------------------------------------------------------------------------
// pileup_consensus_caller_unit
// Pileup majority-consensus caller: per-position base counts, margin test
// against a programmable fraction of coverage, saturating mismatch counter.
// ----------------------------------------------------------------------------
// After reset the unit clears its count table, one row per cycle, for all
// MAX_READ_LEN rows with req_ready low; threshold writes are taken during
// that time. Each item then goes from acceptance to result through one
// read-modify-write of the table row over the registered read and the single
// write port, two ranking steps, the threshold multiply and the margin
// compare. One item is worked at a time; the next one is accepted while the
// previous result still waits in the output register, and a result that has
// not been taken holds the unit in its final step.
module pileup_consensus_caller_unit
   import pcc_pkg::*;
#(
   parameter int MAX_READ_LEN = 256,
   parameter int COUNT_WIDTH  = 16
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_item,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_item,
   input  logic       csr_wr_en,
   input  logic [8:0] csr_wr_data
);

   cmd_type    cmd;
   status_type status;

   // sequencing
   pcc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // table and arithmetic
   pcc_datapath #(
      .MAX_READ_LEN (MAX_READ_LEN),
      .COUNT_WIDTH  (COUNT_WIDTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_item    (req_item),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_item    (rsp_item)
   );

   // no transfer accepted right after reset, the table is being cleared
   a_clear_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !req_ready)
      else $error("input accepted during table clearing");

   // a result is never loaded over one that has not been taken
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!rsp_valid || rsp_ready))
      else $error("pending result overwritten");

   // datapath steps never overlap
   a_one_step: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd))
      else $error("more than one datapath step at once");

   // a called base always has coverage, and a change implies a call
   a_call_consistent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_item.changed || rsp_item.replaced) &&
                    (!rsp_item.replaced || rsp_item.coverage != 18'd0))
      else $error("inconsistent call flags in result");

endmodule
